// ----- rtl/sdrs_pkg.sv -----
package sdrs_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int FILL_W      = $clog2(MAX_RECORDS + 1);
  localparam int KEY_W       = 16;
  localparam int ID_W        = 8;
  localparam int CNT_W       = 8;
  localparam int DATA_W      = KEY_W + ID_W + CNT_W;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } rec_t;

  typedef struct packed {
    logic ins;
    logic shl;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/sdrs_cell.sv -----
module sdrs_cell (
  input  logic              clk,
  input  sdrs_pkg::cell_ctrl_t ctrl,
  input  logic              occupied,
  input  sdrs_pkg::rec_t    new_rec,
  input  logic              left_keep,
  input  sdrs_pkg::rec_t    left_rec,
  input  sdrs_pkg::rec_t    right_rec,
  output sdrs_pkg::rec_t    rec,
  output logic              keep
);
  import sdrs_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;

  assign keep = occupied && (rec_r.key >= new_rec.key);
  assign rec  = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    if (ctrl.ins) begin
      if (keep) begin
        rec_nxt = rec_r;
      end else if (left_keep) begin
        rec_nxt = new_rec;
      end else begin
        rec_nxt = left_rec;
      end
    end else if (ctrl.shl) begin
      rec_nxt = right_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

// ----- rtl/stable_descending_record_sort.sv -----
// stable descending record sort
// in channel: one record per beat, in_tdata = key, id, count from the low
// bit up, in_tlast closes the set. records are kept in key order, highest
// first, in a chain of insertion cells; equal keys stay in load order.
// while loading, in_tready stays high: every cell compares the new key and
// either holds, takes the new record, or takes its left neighbor's record.
// after the closing beat the chain shifts toward cell 0 once per cycle while
// the output register is free, and each record leaves through that register:
// the first record leaves the chain in the cycle after the closing beat unless
// the output stalls and is valid in the cycle after its shift, then one result
// per cycle unless stalled. in_tready is low while a set is being emitted.
// out channel: out_tdata = {count, id, key}, out_tuser = overflow (set on
// every result of a set that lost records beyond the chain length),
// out_tlast marks the last result of the set.
// a stalled out_tready holds the output register and pauses the shifting.
// synchronous active-low reset empties the chain and clears the flags.
module stable_descending_record_sort (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sdrs_pkg::DATA_W-1:0] in_tdata,  // sort_key, record_id, member_count
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sdrs_pkg::DATA_W-1:0] out_tdata, // out_key, out_id, out_count
  output logic                        out_tuser, // overflow
  output logic                        out_tlast
);
  import sdrs_pkg::*;

  state_t               state_r, state_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic                 dropped_r, dropped_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  rec_t                 out_rec_r, out_rec_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_user_r, out_user_nxt;

  logic                 accept;
  logic                 full;
  logic                 out_free;
  cell_ctrl_t           ctrl;
  rec_t                 new_rec;
  rec_t                 cell_rec  [MAX_RECORDS];
  logic                 cell_keep [MAX_RECORDS];

  assign new_rec  = rec_t'(in_tdata);
  assign full     = (fill_r == FILL_W'(MAX_RECORDS));
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_RECORDS; gi++) begin : g_cell
      logic occ;
      logic lkeep;
      rec_t lrec;
      rec_t rrec;
      assign occ = (fill_r > FILL_W'(gi));
      if (gi == 0) begin : g_first
        assign lkeep = 1'b1;
        assign lrec  = new_rec;
      end else begin : g_mid
        assign lkeep = cell_keep[gi-1];
        assign lrec  = cell_rec[gi-1];
      end
      if (gi == MAX_RECORDS - 1) begin : g_end
        assign rrec = cell_rec[gi];
      end else begin : g_inner
        assign rrec = cell_rec[gi+1];
      end
      sdrs_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occupied  (occ),
        .new_rec   (new_rec),
        .left_keep (lkeep),
        .left_rec  (lrec),
        .right_rec (rrec),
        .rec       (cell_rec[gi]),
        .keep      (cell_keep[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && in_tlast) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && fill_r == FILL_W'(1)) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ctrl      = '0;
    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        ctrl.ins  = in_tvalid && !full;
      end
      ST_EMIT: begin
        ctrl.shl = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    fill_nxt      = fill_r;
    dropped_nxt   = dropped_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_rec_nxt   = out_rec_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    if (ctrl.ins) fill_nxt = fill_r + FILL_W'(1);
    if (ctrl.shl) fill_nxt = fill_r - FILL_W'(1);
    if (accept && full) dropped_nxt = 1'b1;
    if (accept && in_tlast) begin
      ovf_nxt     = dropped_r || full;
      dropped_nxt = 1'b0;
    end
    if (ctrl.shl) begin
      out_valid_nxt = 1'b1;
      out_rec_nxt   = cell_rec[0];
      out_last_nxt  = (fill_r == FILL_W'(1));
      out_user_nxt  = ovf_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      dropped_r   <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      dropped_r   <= dropped_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_rec_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_RECORDS))
    else $error("fill level beyond chain length");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> fill_r != '0)
    else $error("emitting from an empty chain");

  a_close_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (state_r == ST_EMIT && fill_r != '0))
    else $error("closing beat did not start emission");

  a_shift_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.shl |=> out_tvalid)
    else $error("shifted record not presented");
`endif

endmodule

// ----- dv/record_sort_checker.sv -----
`timescale 1ns / 1ps

module record_sort_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [sdrs_pkg::DATA_W-1:0] in_tdata,  // sort_key, record_id, member_count
  input  logic                        in_tlast,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [sdrs_pkg::DATA_W-1:0] out_tdata, // out_key, out_id, out_count
  input  logic                        out_tuser, // overflow
  input  logic                        out_tlast,
  output int unsigned                 mismatches,
  output int unsigned                 pending
);

  typedef struct {
    logic [sdrs_pkg::KEY_W-1:0] key;
    logic [sdrs_pkg::ID_W-1:0]  id;
    logic [sdrs_pkg::CNT_W-1:0] cnt;
    logic                       ovf;
    logic                       eos;
  } sorted_rec_t;

  sdrs_pkg::rec_t sorted_store[$];
  logic           records_dropped = 1'b0;
  sorted_rec_t    expected_results[$];
  int unsigned    err_cnt = 0;

  // insertion after every held record with key greater or equal keeps load order
  task automatic load_record(input sdrs_pkg::rec_t rec, input logic closing);
    int          pos;
    sorted_rec_t res;
    if (sorted_store.size() >= sdrs_pkg::MAX_RECORDS) begin
      records_dropped = 1'b1;
    end else begin
      pos = 0;
      while (pos < sorted_store.size() && sorted_store[pos].key >= rec.key) pos++;
      sorted_store.insert(pos, rec);
    end
    if (closing) begin
      foreach (sorted_store[k]) begin
        res.key = sorted_store[k].key;
        res.id  = sorted_store[k].id;
        res.cnt = sorted_store[k].cnt;
        res.ovf = records_dropped;
        res.eos = (k == sorted_store.size() - 1);
        expected_results.push_back(res);
      end
      sorted_store.delete();
      records_dropped = 1'b0;
    end
  endtask

  task automatic check_result(input sdrs_pkg::rec_t rec, input logic ovf, input logic eos);
    sorted_rec_t exp_res;
    if (expected_results.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("%0t: unexpected result key=%h id=%h cnt=%h ovf=%b eos=%b",
                 $realtime, rec.key, rec.id, rec.cnt, ovf, eos);
    end else begin
      exp_res = expected_results.pop_front();
      if (exp_res.key !== rec.key || exp_res.id !== rec.id || exp_res.cnt !== rec.cnt ||
          exp_res.ovf !== ovf || exp_res.eos !== eos) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display({"%0t: mismatch exp key=%h id=%h cnt=%h ovf=%b eos=%b, ",
                    "got key=%h id=%h cnt=%h ovf=%b eos=%b"},
                   $realtime, exp_res.key, exp_res.id, exp_res.cnt, exp_res.ovf, exp_res.eos,
                   rec.key, rec.id, rec.cnt, ovf, eos);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) load_record(sdrs_pkg::rec_t'(in_tdata), in_tlast);
      if (out_tvalid && out_tready)
        check_result(sdrs_pkg::rec_t'(out_tdata), out_tuser, out_tlast);
    end
    mismatches <= err_cnt;
    pending    <= expected_results.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT  = 2000;
  localparam int TARGET_ITEMS = 350;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [sdrs_pkg::DATA_W-1:0] in_tdata;  // sort_key, record_id, member_count
  logic                        in_tlast;
  logic                        out_tvalid;
  logic                        out_tready;
  logic [sdrs_pkg::DATA_W-1:0] out_tdata; // out_key, out_id, out_count
  logic                        out_tuser; // overflow
  logic                        out_tlast;

  int unsigned mismatches;
  int unsigned pending;
  int          snd_idle;
  int          rcv_idle;
  int          items_sent;
  int          quiet_cycles;

  stable_descending_record_sort u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  record_sort_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic [15:0] key, input logic [7:0] id,
                           input logic [7:0] cnt, input logic closing);
    sdrs_pkg::rec_t rec;
    rec.key = key;
    rec.id  = id;
    rec.cnt = cnt;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rec;
    in_tlast  <= closing;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random_set();
    int          n;
    int          key_mode;
    logic [15:0] key;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 16);
    key_mode = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      case (key_mode)
        0: key = 16'($urandom_range(0, 3));
        1: key = 16'hfff0 | 16'($urandom_range(0, 15));
        default: key = 16'($urandom());
      endcase
      send_beat(key, 8'($urandom()), 8'($urandom()), i == n - 1);
    end
    if ($urandom_range(0, 9) == 0) wait_drained();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    snd_idle   = 38;
    rcv_idle   = 74;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single records at both extremes
    send_beat(16'h0000, 8'h00, 8'h00, 1'b1);
    send_beat(16'hffff, 8'hff, 8'hff, 1'b1);
    // equal keys must keep load order
    send_beat(16'd5, 8'd1, 8'd10, 1'b0);
    send_beat(16'd7, 8'd2, 8'd20, 1'b0);
    send_beat(16'd5, 8'd3, 8'd30, 1'b0);
    send_beat(16'd7, 8'd4, 8'd40, 1'b0);
    send_beat(16'd5, 8'd5, 8'd50, 1'b1);
    // full store, closing beat dropped
    for (int i = 0; i < 17; i++)
      send_beat(16'($urandom()), 8'(i), 8'($urandom()), i == 16);

    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin snd_idle = 38; rcv_idle = 74; end
        1: begin snd_idle = 74; rcv_idle = 38; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      while (items_sent < (phase + 1) * TARGET_ITEMS / 3) send_random_set();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sdrs_pkg.sv
rtl/sdrs_cell.sv
rtl/stable_descending_record_sort.sv
dv/record_sort_checker.sv
dv/testbench.sv
